[hw/rtl/b2j_pkg.sv]
// Shared types and constants for the bencode-to-JSON stream converter.
// Used by the nesting stack and the top level; depends on nothing.
package b2j_pkg;

  // Per-container state kept on the nesting stack.
  typedef struct packed {
    logic valpos;  // dictionary waits for the value of a key
    logic has;     // container already holds an element
    logic dict;    // container is a dictionary
  } nest_t;

  // Stack update issued with every accepted byte.
  typedef struct packed {
    logic  en;
    logic  push;
    logic  pop;
    nest_t top;    // new top of stack
    nest_t under;  // old top as it goes below on a push
  } stack_op_t;

  localparam int unsigned MaxOut = 8;

  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_L      = 8'h6c;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7e;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_STRAY_E   = 3'd1;
  localparam logic [2:0] ERR_BAD_DIGIT = 3'd2;
  localparam logic [2:0] ERR_NEST_OVF  = 3'd3;
  localparam logic [2:0] ERR_LEN_OVF   = 3'd4;

  // Lowercase hex digit for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CH_0 + {4'd0, nib};
    end else begin
      r = 8'h57 + {4'd0, nib};
    end
    return r;
  endfunction

endpackage

[hw/rtl/bencode_to_json_stream_core.sv]
// Bencode-to-JSON stream converter. First JSON byte is valid in the cycle
// after the input transfer. One input byte per cycle while each byte yields
// at most one result and the output is ready; a byte with several results
// holds the result register until the last leaves; the next byte is taken
// as it leaves. Reset: top-level value expected, empty stack, no result.
module bencode_to_json_stream_core import b2j_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       value_done_o,
  output logic [2:0] error_code_o
);

  localparam int unsigned PtrW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AccW = COUNT_WIDTH + 4;

  typedef enum logic [2:0] {
    PH_TOP, PH_VALUE, PH_INT, PH_LEN, PH_STR, PH_DONE, PH_ERR
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] rem_q, rem_d;
  logic [7:0]             obuf_q [MaxOut];
  logic [7:0]             obuf_d [MaxOut];
  logic [3:0]             cnt_q, idx_q, n;
  logic                   done_q, done_d;
  logic [2:0]             err_q, err_d;

  stack_op_t              sop;
  nest_t                  cur, below, base, cv_top, t;
  logic [PtrW-1:0]        ptr;
  logic                   accept, out_fire, out_last;
  logic [7:0]             c;
  logic [3:0]             dig;
  logic                   is_i, is_ld, is_dig, full, ptr_zero;
  logic [2:0]             vchk;
  logic                   bv, cv, cv_ptr_zero;
  logic [AccW-1:0]        acc;

  b2j_nest_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (sop),
    .top_o   (cur),
    .below_o (below),
    .ptr_o   (ptr)
  );

  assign c        = in_byte_i;
  assign dig      = c[3:0];
  assign is_i     = (c == CH_I);
  assign is_ld    = (c == CH_L) || (c == CH_D);
  assign is_dig   = (c >= CH_0) && (c <= CH_9);
  assign full     = (ptr >= PtrW'(STACK_DEPTH));
  assign ptr_zero = (ptr == '0);
  assign acc      = {1'b0, rem_q, 3'b000} + {3'b000, rem_q, 1'b0} + AccW'(dig);

  // Error that a byte at a value position raises, if any.
  always_comb begin
    if (is_i || is_dig) begin
      vchk = ERR_NONE;
    end else if (is_ld) begin
      vchk = full ? ERR_NEST_OVF : ERR_NONE;
    end else begin
      vchk = ERR_BAD_DIGIT;
    end
  end

  // Result register drains one byte per transfer.
  assign out_valid_o  = (idx_q != cnt_q);
  assign out_last     = ((idx_q + 4'd1) == cnt_q);
  assign out_fire     = out_valid_o && out_ready_i;
  assign out_byte_o   = obuf_q[idx_q[2:0]];
  assign out_last_o   = out_last;
  assign value_done_o = out_last && done_q;
  assign error_code_o = out_last ? err_q : ERR_NONE;
  assign in_ready_o   = !out_valid_o || (out_fire && out_last);
  assign accept       = in_valid_i && in_ready_o;

  always_comb begin
    phase_d     = phase_q;
    rem_d       = rem_q;
    n           = 4'd0;
    done_d      = 1'b0;
    err_d       = ERR_NONE;
    bv          = 1'b0;
    cv          = 1'b0;
    cv_top      = cur;
    cv_ptr_zero = ptr_zero;
    base        = cur;
    t           = cur;
    for (int k = 0; k < MaxOut; k++) begin
      obuf_d[k] = 8'h00;
    end
    sop.en    = accept;
    sop.push  = 1'b0;
    sop.pop   = 1'b0;
    sop.top   = cur;
    sop.under = cur;

    unique case (phase_q)
      PH_TOP: begin
        if (c == CH_E) begin
          err_d = ERR_STRAY_E;
        end else if (vchk != ERR_NONE) begin
          err_d = vchk;
        end else begin
          bv = 1'b1;
        end
      end
      PH_VALUE: begin
        if (ptr_zero) begin
          cv = 1'b1;
        end else if (cur.valpos) begin
          if (vchk != ERR_NONE) begin
            err_d = vchk;
          end else begin
            bv = 1'b1;
          end
        end else if (c == CH_E) begin
          obuf_d[n[2:0]] = cur.dict ? CH_RBRACE : CH_RBRACK;
          n = n + 4'd1;
          sop.pop     = 1'b1;
          cv          = 1'b1;
          cv_top      = below;
          cv_ptr_zero = (ptr == PtrW'(1));
        end else if (vchk != ERR_NONE) begin
          err_d = vchk;
        end else begin
          if (cur.has) begin
            obuf_d[n[2:0]] = CH_COMMA;
            n = n + 4'd1;
          end
          base.has = 1'b1;
          bv       = 1'b1;
        end
      end
      PH_INT: begin
        if (c == CH_E) begin
          cv = 1'b1;
        end else begin
          obuf_d[n[2:0]] = c;
          n = n + 4'd1;
        end
      end
      PH_LEN: begin
        if (c == CH_COLON) begin
          obuf_d[n[2:0]] = CH_QUOTE;
          n = n + 4'd1;
          if (rem_q == '0) begin
            obuf_d[n[2:0]] = CH_QUOTE;
            n  = n + 4'd1;
            cv = 1'b1;
          end else begin
            phase_d = PH_STR;
          end
        end else if (is_dig) begin
          if (acc[AccW-1:COUNT_WIDTH] != 4'd0) begin
            err_d = ERR_LEN_OVF;
          end else begin
            rem_d = acc[COUNT_WIDTH-1:0];
          end
        end else begin
          err_d = ERR_BAD_DIGIT;
        end
      end
      PH_STR: begin
        if (rem_q == '0) begin
          cv = 1'b1;
        end else begin
          if ((c == CH_QUOTE) || (c == CH_BSLASH)) begin
            obuf_d[n[2:0]] = CH_BSLASH;
            n = n + 4'd1;
            obuf_d[n[2:0]] = c;
            n = n + 4'd1;
          end else if ((c >= CH_SPACE) && (c <= CH_TILDE)) begin
            obuf_d[n[2:0]] = c;
            n = n + 4'd1;
          end else begin
            obuf_d[n[2:0]] = CH_BSLASH;
            n = n + 4'd1;
            obuf_d[n[2:0]] = CH_U;
            n = n + 4'd1;
            obuf_d[n[2:0]] = CH_0;
            n = n + 4'd1;
            obuf_d[n[2:0]] = CH_0;
            n = n + 4'd1;
            obuf_d[n[2:0]] = hex_char(c[7:4]);
            n = n + 4'd1;
            obuf_d[n[2:0]] = hex_char(c[3:0]);
            n = n + 4'd1;
          end
          rem_d = rem_q - COUNT_WIDTH'(1);
          if (rem_q == COUNT_WIDTH'(1)) begin
            obuf_d[n[2:0]] = CH_QUOTE;
            n  = n + 4'd1;
            cv = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (err_d != ERR_NONE) begin
      phase_d = PH_ERR;
    end

    // Start of a new value at a value position.
    if (bv) begin
      sop.top   = base;
      sop.under = base;
      if (is_i) begin
        phase_d = PH_INT;
      end else if (is_ld) begin
        sop.push       = 1'b1;
        sop.top        = '{valpos: 1'b0, has: 1'b0, dict: (c == CH_D)};
        obuf_d[n[2:0]] = (c == CH_D) ? CH_LBRACE : CH_LBRACK;
        n              = n + 4'd1;
        phase_d        = PH_VALUE;
      end else begin
        rem_d   = COUNT_WIDTH'(dig);
        phase_d = PH_LEN;
      end
    end

    // A value finished: either the whole document or one element.
    if (cv) begin
      if (cv_ptr_zero) begin
        phase_d = PH_DONE;
        done_d  = 1'b1;
      end else begin
        t = cv_top;
        if (t.dict) begin
          if (!t.valpos) begin
            obuf_d[n[2:0]] = CH_COLON;
            n        = n + 4'd1;
            t.valpos = 1'b1;
          end else begin
            t.valpos = 1'b0;
          end
        end
        sop.top = t;
        phase_d = PH_VALUE;
      end
    end

    // Status with no character still needs one result.
    if ((n == 4'd0) && (done_d || (err_d != ERR_NONE))) begin
      n = 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < MaxOut; k++) begin
        obuf_q[k] <= obuf_d[k];
      end
      done_q <= done_d;
      err_q  <= err_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TOP;
      cnt_q   <= 4'd0;
      idx_q   <= 4'd0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        cnt_q   <= n;
        idx_q   <= 4'd0;
      end else if (out_fire) begin
        idx_q <= idx_q + 4'd1;
      end
    end
  end

endmodule

[hw/rtl/b2j_nest_stack.sv]
// Nesting stack: top entry in a register, the rest in a memory with a
// registered read of the entry just below the top. Uses b2j_pkg.
module b2j_nest_stack import b2j_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  stack_op_t                            op_i,
  output nest_t                                top_o,
  output nest_t                                below_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0]     ptr_o
);

  localparam int unsigned PtrW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  nest_t             mem [STACK_DEPTH];
  nest_t             top_q;
  nest_t             rd_q;
  nest_t             byp_data_q;
  logic              byp_q;
  logic [PtrW-1:0]   ptr_q, ptr_d;
  logic [AddrW-1:0]  waddr, raddr;
  logic              we;

  always_comb begin
    ptr_d = ptr_q;
    if (op_i.en && op_i.push) begin
      ptr_d = ptr_q + PtrW'(1);
    end else if (op_i.en && op_i.pop) begin
      ptr_d = ptr_q - PtrW'(1);
    end
  end

  assign we    = op_i.en && op_i.push && (ptr_q != '0);
  assign waddr = AddrW'(ptr_q - PtrW'(1));
  // Prefetch the entry below the next top so a pop can use it at once.
  assign raddr = AddrW'(ptr_d - PtrW'(2));

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= op_i.under;
    end
    rd_q       <= mem[raddr];
    byp_q      <= we && (waddr == raddr);
    byp_data_q <= op_i.under;
    if (op_i.en) begin
      top_q <= op_i.top;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  assign top_o   = top_q;
  assign below_o = byp_q ? byp_data_q : rd_q;
  assign ptr_o   = ptr_q;

endmodule
